// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge, disabled while reset is high
`define ASSERT_CLK(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== rtl/core/psbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Pileup strand base counter package
// Character codes, queue sizing, class encoding and shared types.
// ----------------------------------------------------------------------------
package psbc_pkg;

  localparam int MAX_READ_DEPTH = 131072;
  localparam int QADDR_W        = $clog2(MAX_READ_DEPTH);
  localparam int QPTR_W         = QADDR_W + 1;

  localparam int POS_W   = 31;
  localparam int CNT_W   = 18;
  localparam int INDEL_W = 17;
  localparam int MBQ_W   = 7;

  localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [INDEL_W-1:0] INDEL_MAX = {INDEL_W{1'b1}};

  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_BANG    = 8'h21;
  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_CARET   = 8'h5E;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  localparam logic [2:0] FIELD_POSITION = 3'd1;
  localparam logic [2:0] FIELD_REF      = 3'd2;
  localparam logic [2:0] FIELD_BASES    = 3'd4;
  localparam logic [2:0] FIELD_QUALITY  = 3'd5;
  localparam logic [2:0] FIELD_LAST     = 3'd7;

  typedef enum logic [1:0] {
    SUB_BASE,
    SUB_SKIP_MAPQ,
    SUB_INDEL_LEN,
    SUB_INDEL_SKIP
  } substate_t;

  typedef struct packed {
    logic       counted;
    logic       rev;
    logic [1:0] base;
  } class_t;

  typedef struct packed {
    logic               en;
    logic [QADDR_W-1:0] addr;
    class_t             cls;
  } queue_wr_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } base_code_t;

  function automatic base_code_t base_code(input logic [7:0] c);
    base_code_t r;
    r.valid = 1'b1;
    unique case (c)
      "A", "a": r.code = 2'd0;
      "T", "t": r.code = 2'd1;
      "G", "g": r.code = 2'd2;
      "C", "c": r.code = 2'd3;
      default: begin
        r.valid = 1'b0;
        r.code  = 2'd0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/psbc_class_queue.sv =====
// ----------------------------------------------------------------------------
// Base class queue
// One write port, one read port memory holding the decoded base classes.
// ----------------------------------------------------------------------------
module psbc_class_queue (
  input  logic                         clk,
  input  psbc_pkg::queue_wr_t          wr,
  input  logic [psbc_pkg::QADDR_W-1:0] rd_addr,
  output psbc_pkg::class_t             rd_class
);

  psbc_pkg::class_t mem [psbc_pkg::MAX_READ_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.cls;
    end
  end

  always_ff @(posedge clk) begin
    rd_class <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/pileup_strand_base_counter.sv =====
// ----------------------------------------------------------------------------
// Pileup strand base counter
// Parses pileup text one byte per cycle, a held-off newline apart, into per-strand base counts.
// ----------------------------------------------------------------------------
// Takes one text byte per clock cycle; each byte needs at most one queue write
// or one queue read. The class queue is a single memory with one write and one
// registered read port, prefetched at the read pointer so a quality byte pops
// in the cycle it arrives. A newline is held off only while the previous result
// sits in the output register and the output is stalled; every other byte is
// taken. The queue needs no clearing pass after reset.
module pileup_strand_base_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psbc_pkg::MBQ_W-1:0]    min_base_quality,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    text_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [psbc_pkg::POS_W-1:0]    site_position,
  output logic [7:0]                    reference_char,
  output logic [psbc_pkg::CNT_W-1:0]    fwd_a_count,
  output logic [psbc_pkg::CNT_W-1:0]    fwd_t_count,
  output logic [psbc_pkg::CNT_W-1:0]    fwd_g_count,
  output logic [psbc_pkg::CNT_W-1:0]    fwd_c_count,
  output logic [psbc_pkg::CNT_W-1:0]    rev_a_count,
  output logic [psbc_pkg::CNT_W-1:0]    rev_t_count,
  output logic [psbc_pkg::CNT_W-1:0]    rev_g_count,
  output logic [psbc_pkg::CNT_W-1:0]    rev_c_count
);

  `include "assert_macros.svh"

  logic [psbc_pkg::MBQ_W-1:0]   mbq;
  logic [2:0]                   field_index, field_index_next;
  logic [psbc_pkg::POS_W-1:0]   position_accum, position_accum_next;
  logic [7:0]                   ref_byte, ref_byte_next;
  logic [1:0]                   ref_code, ref_code_next;
  logic                         ref_taken, ref_taken_next;
  psbc_pkg::substate_t          base_substate, base_substate_next;
  logic [psbc_pkg::INDEL_W-1:0] indel_remaining, indel_remaining_next;
  logic [psbc_pkg::QPTR_W-1:0]  write_ptr, write_ptr_next;
  logic [psbc_pkg::QPTR_W-1:0]  read_ptr, read_ptr_next;
  logic [psbc_pkg::CNT_W-1:0]   counts [8];
  logic [psbc_pkg::CNT_W-1:0]   counts_next [8];
  logic [psbc_pkg::CNT_W-1:0]   out_counts [8];

  logic                         accept;
  logic                         is_newline;
  logic                         load_result;
  psbc_pkg::queue_wr_t          qwr;
  psbc_pkg::class_t             rd_class;

  assign cfg_ready   = 1'b1;
  assign is_newline  = (text_byte == psbc_pkg::CHAR_NEWLINE);
  assign in_stall    = out_valid && out_stall && is_newline;
  assign accept      = in_valid && !in_stall;
  assign load_result = accept && is_newline;

  always_ff @(posedge clk) begin
    if (rst) begin
      mbq <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mbq <= min_base_quality;
    end
  end

  psbc_class_queue u_queue (
    .clk      (clk),
    .wr       (qwr),
    .rd_addr  (read_ptr_next[psbc_pkg::QADDR_W-1:0]),
    .rd_class (rd_class)
  );

  always_comb begin
    logic                         digit;
    logic [3:0]                   digit_val;
    logic [psbc_pkg::POS_W+3:0]   pos_mul;
    logic [psbc_pkg::INDEL_W+3:0] indel_mul;
    logic                         do_decode;
    logic                         do_push;
    psbc_pkg::class_t             push_cls;
    psbc_pkg::base_code_t         bc;
    logic [7:0]                   qual;
    logic                         pass;
    logic [2:0]                   cidx;
    logic                         do_count;
    logic [psbc_pkg::INDEL_W-1:0] indel_dec;

    field_index_next     = field_index;
    position_accum_next  = position_accum;
    ref_byte_next        = ref_byte;
    ref_code_next        = ref_code;
    ref_taken_next       = ref_taken;
    base_substate_next   = base_substate;
    indel_remaining_next = indel_remaining;
    write_ptr_next       = write_ptr;
    read_ptr_next        = read_ptr;
    counts_next          = counts;

    digit     = (text_byte >= psbc_pkg::CHAR_ZERO) && (text_byte <= psbc_pkg::CHAR_NINE);
    digit_val = 4'(text_byte - psbc_pkg::CHAR_ZERO);
    pos_mul   = ({4'd0, position_accum} << 3) + ({4'd0, position_accum} << 1)
              + (psbc_pkg::POS_W+4)'(digit_val);
    indel_mul = ({4'd0, indel_remaining} << 3) + ({4'd0, indel_remaining} << 1)
              + (psbc_pkg::INDEL_W+4)'(digit_val);
    bc        = psbc_pkg::base_code(text_byte);
    indel_dec = indel_remaining - psbc_pkg::INDEL_W'(1);
    do_decode = 1'b0;
    do_push   = 1'b0;
    push_cls  = '0;
    qual      = text_byte - psbc_pkg::CHAR_BANG;
    pass      = (mbq == '0) || ((text_byte >= psbc_pkg::CHAR_BANG) && (qual >= {1'b0, mbq}));
    cidx      = {rd_class.rev, rd_class.base};
    do_count  = 1'b0;

    if (accept) begin
      if (is_newline) begin
        field_index_next     = '0;
        position_accum_next  = '0;
        ref_byte_next        = '0;
        ref_taken_next       = 1'b0;
        base_substate_next   = psbc_pkg::SUB_BASE;
        indel_remaining_next = '0;
        write_ptr_next       = '0;
        read_ptr_next        = '0;
        for (int k = 0; k < 8; k++) begin
          counts_next[k] = '0;
        end
      end else if (text_byte == psbc_pkg::CHAR_TAB) begin
        if (field_index != psbc_pkg::FIELD_LAST) begin
          field_index_next = field_index + 3'd1;
        end
        base_substate_next   = psbc_pkg::SUB_BASE;
        indel_remaining_next = '0;
      end else begin
        priority case (field_index)
          psbc_pkg::FIELD_POSITION: begin
            if (digit) begin
              position_accum_next = (pos_mul > (psbc_pkg::POS_W+4)'(psbc_pkg::POS_MAX))
                                  ? psbc_pkg::POS_MAX : pos_mul[psbc_pkg::POS_W-1:0];
            end
          end
          psbc_pkg::FIELD_REF: begin
            if (!ref_taken) begin
              ref_byte_next  = text_byte;
              ref_taken_next = 1'b1;
              if (bc.valid) begin
                ref_code_next = bc.code;
              end
            end
          end
          psbc_pkg::FIELD_BASES: begin
            unique case (base_substate)
              psbc_pkg::SUB_SKIP_MAPQ: begin
                base_substate_next = psbc_pkg::SUB_BASE;
              end
              psbc_pkg::SUB_INDEL_LEN: begin
                if (digit) begin
                  indel_remaining_next =
                    (indel_mul > (psbc_pkg::INDEL_W+4)'(psbc_pkg::INDEL_MAX))
                    ? psbc_pkg::INDEL_MAX : indel_mul[psbc_pkg::INDEL_W-1:0];
                end else if (indel_remaining == '0) begin
                  base_substate_next = psbc_pkg::SUB_BASE;
                  do_decode          = 1'b1;
                end else begin
                  indel_remaining_next = indel_dec;
                  base_substate_next   = (indel_dec == '0) ? psbc_pkg::SUB_BASE
                                                           : psbc_pkg::SUB_INDEL_SKIP;
                end
              end
              psbc_pkg::SUB_INDEL_SKIP: begin
                if (indel_remaining != '0) begin
                  indel_remaining_next = indel_dec;
                end
                if (indel_remaining <= psbc_pkg::INDEL_W'(1)) begin
                  base_substate_next = psbc_pkg::SUB_BASE;
                end
              end
              default: begin
                do_decode = 1'b1;
              end
            endcase
          end
          psbc_pkg::FIELD_QUALITY: begin
            if (read_ptr < write_ptr) begin
              read_ptr_next = read_ptr + psbc_pkg::QPTR_W'(1);
              do_count      = rd_class.counted && pass;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (do_decode) begin
      priority if (text_byte == psbc_pkg::CHAR_CARET) begin
        base_substate_next = psbc_pkg::SUB_SKIP_MAPQ;
      end else if (text_byte == psbc_pkg::CHAR_DOLLAR) begin
      end else if (text_byte == psbc_pkg::CHAR_PLUS || text_byte == psbc_pkg::CHAR_MINUS) begin
        base_substate_next   = psbc_pkg::SUB_INDEL_LEN;
        indel_remaining_next = '0;
      end else if (text_byte == psbc_pkg::CHAR_DOT) begin
        do_push  = 1'b1;
        push_cls = '{counted: 1'b1, rev: 1'b0, base: ref_code};
      end else if (text_byte == psbc_pkg::CHAR_COMMA) begin
        do_push  = 1'b1;
        push_cls = '{counted: 1'b1, rev: 1'b1, base: ref_code};
      end else if (bc.valid) begin
        do_push  = 1'b1;
        push_cls = '{counted: 1'b1, rev: (text_byte >= psbc_pkg::CHAR_LOWER_A),
                     base: bc.code};
      end else begin
        // star and unknown bytes take a quality byte but are never counted
        do_push  = 1'b1;
        push_cls = '0;
      end
    end

    qwr.en   = do_push && (write_ptr < psbc_pkg::QPTR_W'(psbc_pkg::MAX_READ_DEPTH));
    qwr.addr = write_ptr[psbc_pkg::QADDR_W-1:0];
    qwr.cls  = push_cls;
    if (qwr.en) begin
      write_ptr_next = write_ptr + psbc_pkg::QPTR_W'(1);
    end

    for (int k = 0; k < 8; k++) begin
      if (do_count && (cidx == 3'(k)) && (counts[k] != psbc_pkg::CNT_MAX)) begin
        counts_next[k] = counts[k] + psbc_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index     <= '0;
      position_accum  <= '0;
      ref_byte        <= '0;
      ref_code        <= '0;
      ref_taken       <= 1'b0;
      base_substate   <= psbc_pkg::SUB_BASE;
      indel_remaining <= '0;
      write_ptr       <= '0;
      read_ptr        <= '0;
      for (int k = 0; k < 8; k++) begin
        counts[k] <= '0;
      end
    end else begin
      field_index     <= field_index_next;
      position_accum  <= position_accum_next;
      ref_byte        <= ref_byte_next;
      ref_code        <= ref_code_next;
      ref_taken       <= ref_taken_next;
      base_substate   <= base_substate_next;
      indel_remaining <= indel_remaining_next;
      write_ptr       <= write_ptr_next;
      read_ptr        <= read_ptr_next;
      counts          <= counts_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load_result || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      site_position  <= position_accum;
      reference_char <= ref_byte;
      out_counts     <= counts;
    end
  end

  assign fwd_a_count = out_counts[0];
  assign fwd_t_count = out_counts[1];
  assign fwd_g_count = out_counts[2];
  assign fwd_c_count = out_counts[3];
  assign rev_a_count = out_counts[4];
  assign rev_t_count = out_counts[5];
  assign rev_g_count = out_counts[6];
  assign rev_c_count = out_counts[7];

  `ASSERT_ALWAYS(a_reset_idles_output, clk, rst |=> !out_valid, "output valid after reset")
  `ASSERT_CLK(a_read_behind_write, clk, rst, read_ptr <= write_ptr, "queue read passed write")
  `ASSERT_CLK(a_write_in_range, clk, rst,
    write_ptr <= psbc_pkg::QPTR_W'(psbc_pkg::MAX_READ_DEPTH),
    "queue write pointer overran depth")
  `ASSERT_CLK(a_newline_clears, clk, rst,
    load_result |=> out_valid && field_index == '0 && write_ptr == '0 && read_ptr == '0,
    "newline did not clear line state")
  `ASSERT_CLK(a_push_only_bases, clk, rst,
    accept && !is_newline && field_index != psbc_pkg::FIELD_BASES |=> $stable(write_ptr),
    "queue push outside base field")

endmodule

// ===== test/pileup_strand_base_counter_tb.sv =====
// ----------------------------------------------------------------------------
// Pileup strand base counter testbench
// Streams directed and random pileup text through the counter, predicts the
// result of every line and compares each result field by field.
// ----------------------------------------------------------------------------
module pileup_strand_base_counter_tb;

  localparam int unsigned RUN_LIMIT       = 100_000;
  localparam int          DRAIN_GAP       = 4;
  localparam int          HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [psbc_pkg::POS_W-1:0]   position;
    logic [7:0]                   ref_char;
    logic [8*psbc_pkg::CNT_W-1:0] counts;
  } site_t;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [psbc_pkg::MBQ_W-1:0]   min_base_quality = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [7:0]                   text_byte = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [psbc_pkg::POS_W-1:0]   site_position;
  logic [7:0]                   reference_char;
  logic [psbc_pkg::CNT_W-1:0]   fwd_a_count, fwd_t_count, fwd_g_count, fwd_c_count;
  logic [psbc_pkg::CNT_W-1:0]   rev_a_count, rev_t_count, rev_g_count, rev_c_count;

  logic [7:0]                   text_queue [$];
  site_t                        expected_sites [$];
  int unsigned                  mismatches = 0;
  int unsigned                  cycle_count = 0;
  int unsigned                  send_idle_pct = 0;
  int unsigned                  recv_idle_pct = 0;
  bit                           hold_off_armed = 1'b0;
  bit                           hold_taken;
  int unsigned                  hold_left;

  // predicted line state
  logic [2:0]                   pu_field;
  logic [psbc_pkg::POS_W-1:0]   pu_position;
  logic [7:0]                   pu_ref_char;
  logic [1:0]                   pu_ref_base;
  logic                         pu_ref_seen;
  psbc_pkg::substate_t          pu_mode;
  int unsigned                  pu_indel_left;
  psbc_pkg::class_t             pu_classes [psbc_pkg::MAX_READ_DEPTH];
  int unsigned                  pu_wr;
  int unsigned                  pu_rd;
  logic [psbc_pkg::CNT_W-1:0]   pu_tally [8];
  logic [psbc_pkg::MBQ_W-1:0]   pu_min_qual;

  pileup_strand_base_counter dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .min_base_quality (min_base_quality),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .text_byte        (text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .site_position    (site_position),
    .reference_char   (reference_char),
    .fwd_a_count      (fwd_a_count),
    .fwd_t_count      (fwd_t_count),
    .fwd_g_count      (fwd_g_count),
    .fwd_c_count      (fwd_c_count),
    .rev_a_count      (rev_a_count),
    .rev_t_count      (rev_t_count),
    .rev_g_count      (rev_g_count),
    .rev_c_count      (rev_c_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int nucleotide(input logic [7:0] c);
    case (c | 8'h20)
      "a": return 0;
      "t": return 1;
      "g": return 2;
      "c": return 3;
      default: return -1;
    endcase
  endfunction

  function automatic psbc_pkg::class_t counted_class(input logic rev, input logic [1:0] b);
    psbc_pkg::class_t k;
    k.counted = 1'b1;
    k.rev     = rev;
    k.base    = b;
    return k;
  endfunction

  task automatic start_new_line();
    pu_field      = '0;
    pu_position   = '0;
    pu_ref_char   = '0;
    pu_ref_seen   = 1'b0;
    pu_mode       = psbc_pkg::SUB_BASE;
    pu_indel_left = 0;
    pu_wr         = 0;
    pu_rd         = 0;
    foreach (pu_tally[i]) pu_tally[i] = '0;
  endtask

  task automatic queue_class(input psbc_pkg::class_t k);
    if (pu_wr < psbc_pkg::MAX_READ_DEPTH) begin
      pu_classes[pu_wr] = k;
      pu_wr++;
    end
  endtask

  task automatic decode_read_base(input logic [7:0] c);
    int n;
    n = nucleotide(c);
    if (c == psbc_pkg::CHAR_CARET) begin
      pu_mode = psbc_pkg::SUB_SKIP_MAPQ;
    end else if (c == psbc_pkg::CHAR_PLUS || c == psbc_pkg::CHAR_MINUS) begin
      pu_mode       = psbc_pkg::SUB_INDEL_LEN;
      pu_indel_left = 0;
    end else if (c == psbc_pkg::CHAR_DOT) begin
      queue_class(counted_class(1'b0, pu_ref_base));
    end else if (c == psbc_pkg::CHAR_COMMA) begin
      queue_class(counted_class(1'b1, pu_ref_base));
    end else if (n >= 0) begin
      queue_class(counted_class(c >= psbc_pkg::CHAR_LOWER_A, n[1:0]));
    end else if (c != psbc_pkg::CHAR_DOLLAR) begin
      queue_class('0);
    end
  endtask

  task automatic read_base_text(input logic [7:0] c);
    int unsigned v;
    case (pu_mode)
      psbc_pkg::SUB_SKIP_MAPQ: pu_mode = psbc_pkg::SUB_BASE;
      psbc_pkg::SUB_INDEL_LEN: begin
        if (c >= psbc_pkg::CHAR_ZERO && c <= psbc_pkg::CHAR_NINE) begin
          v = pu_indel_left * 10 + (c - psbc_pkg::CHAR_ZERO);
          pu_indel_left = (v > psbc_pkg::INDEL_MAX) ? psbc_pkg::INDEL_MAX : v;
        end else if (pu_indel_left == 0) begin
          pu_mode = psbc_pkg::SUB_BASE;
          decode_read_base(c);
        end else begin
          pu_indel_left--;
          pu_mode = (pu_indel_left == 0) ? psbc_pkg::SUB_BASE : psbc_pkg::SUB_INDEL_SKIP;
        end
      end
      psbc_pkg::SUB_INDEL_SKIP: begin
        if (pu_indel_left > 0) pu_indel_left--;
        if (pu_indel_left == 0) pu_mode = psbc_pkg::SUB_BASE;
      end
      default: decode_read_base(c);
    endcase
  endtask

  task automatic score_quality(input logic [7:0] c);
    psbc_pkg::class_t k;
    if (pu_rd < pu_wr) begin
      k = pu_classes[pu_rd];
      pu_rd++;
      if (k.counted && (pu_min_qual == 0 ||
          (c >= psbc_pkg::CHAR_BANG && (c - psbc_pkg::CHAR_BANG) >= pu_min_qual))) begin
        if (pu_tally[{k.rev, k.base}] != psbc_pkg::CNT_MAX)
          pu_tally[{k.rev, k.base}] = pu_tally[{k.rev, k.base}] + 1'b1;
      end
    end
  endtask

  task automatic advance_text(input logic [7:0] c, output bit emitted, output site_t site);
    logic [63:0] grown;
    emitted = 1'b0;
    site    = '0;
    if (c == psbc_pkg::CHAR_NEWLINE) begin
      emitted       = 1'b1;
      site.position = pu_position;
      site.ref_char = pu_ref_char;
      site.counts   = {pu_tally[7], pu_tally[6], pu_tally[5], pu_tally[4],
                       pu_tally[3], pu_tally[2], pu_tally[1], pu_tally[0]};
      start_new_line();
    end else if (c == psbc_pkg::CHAR_TAB) begin
      if (pu_field != psbc_pkg::FIELD_LAST) pu_field = pu_field + 1'b1;
      pu_mode       = psbc_pkg::SUB_BASE;
      pu_indel_left = 0;
    end else begin
      case (pu_field)
        psbc_pkg::FIELD_POSITION: begin
          if (c >= psbc_pkg::CHAR_ZERO && c <= psbc_pkg::CHAR_NINE) begin
            grown = {33'd0, pu_position} * 64'd10 + {56'd0, c}
                  - {56'd0, psbc_pkg::CHAR_ZERO};
            pu_position = (grown > psbc_pkg::POS_MAX) ? psbc_pkg::POS_MAX
                                                      : grown[psbc_pkg::POS_W-1:0];
          end
        end
        psbc_pkg::FIELD_REF: begin
          if (!pu_ref_seen) begin
            pu_ref_char = c;
            pu_ref_seen = 1'b1;
            if (nucleotide(c) >= 0) pu_ref_base = 2'(nucleotide(c));
          end
        end
        psbc_pkg::FIELD_BASES:   read_base_text(c);
        psbc_pkg::FIELD_QUALITY: score_quality(c);
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (text_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        text_byte <= text_queue.pop_front();
      end else begin
        in_valid  <= 1'b0;
        text_byte <= 8'($urandom);
      end
    end
  end

  // receiver stall, with one long hold-off when armed
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_off_armed && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_OFF_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: check each result, then predict from the accepted text byte
  always @(posedge clk) begin
    site_t want;
    site_t next_site;
    bit    emitted;
    if (!rst && out_valid && !out_stall) begin
      if (expected_sites.size() == 0) begin
        $error("unexpected result: site_position %0d", site_position);
        mismatches++;
      end else begin
        want = expected_sites.pop_front();
        check_field("site_position", want.position, site_position);
        check_field("reference_char", want.ref_char, reference_char);
        check_field("fwd_a_count", want.counts[0*psbc_pkg::CNT_W +: psbc_pkg::CNT_W], fwd_a_count);
        check_field("fwd_t_count", want.counts[1*psbc_pkg::CNT_W +: psbc_pkg::CNT_W], fwd_t_count);
        check_field("fwd_g_count", want.counts[2*psbc_pkg::CNT_W +: psbc_pkg::CNT_W], fwd_g_count);
        check_field("fwd_c_count", want.counts[3*psbc_pkg::CNT_W +: psbc_pkg::CNT_W], fwd_c_count);
        check_field("rev_a_count", want.counts[4*psbc_pkg::CNT_W +: psbc_pkg::CNT_W], rev_a_count);
        check_field("rev_t_count", want.counts[5*psbc_pkg::CNT_W +: psbc_pkg::CNT_W], rev_t_count);
        check_field("rev_g_count", want.counts[6*psbc_pkg::CNT_W +: psbc_pkg::CNT_W], rev_g_count);
        check_field("rev_c_count", want.counts[7*psbc_pkg::CNT_W +: psbc_pkg::CNT_W], rev_c_count);
      end
    end
    if (!rst && in_valid && !in_stall) begin
      advance_text(text_byte, emitted, next_site);
      if (emitted) expected_sites.push_back(next_site);
    end
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_queue.push_back(s[i]);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    while (v == psbc_pkg::CHAR_TAB || v == psbc_pkg::CHAR_NEWLINE) v = 8'($urandom_range(255));
    return v;
  endfunction

  function automatic logic [7:0] quality_char();
    int r;
    r = $urandom_range(19);
    case (r)
      0: return ($urandom_range(1) != 0) ? 8'h20 : 8'h00;
      1: return 8'($urandom_range(127, 255));
      2: return 8'd126;
      3: return 8'(psbc_pkg::CHAR_BANG + pu_min_qual
                   - ((pu_min_qual != 0) ? $urandom_range(1) : 0));
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  task automatic add_base_token();
    string alphabet;
    int    len;
    alphabet = ".,ACGTacgt";
    case ($urandom_range(11))
      6: begin
        text_queue.push_back(psbc_pkg::CHAR_CARET);
        text_queue.push_back(plain_byte());
      end
      7: text_queue.push_back(psbc_pkg::CHAR_DOLLAR);
      8: text_queue.push_back(psbc_pkg::CHAR_STAR);
      9: begin
        len = $urandom_range(3);
        text_queue.push_back($urandom_range(1) ? psbc_pkg::CHAR_PLUS : psbc_pkg::CHAR_MINUS);
        if (len != 0) text_queue.push_back(psbc_pkg::CHAR_ZERO + 8'(len));
        repeat (len + $urandom_range(1)) text_queue.push_back(alphabet[$urandom_range(2, 9)]);
      end
      10, 11: text_queue.push_back(plain_byte());
      default: text_queue.push_back(alphabet[$urandom_range(9)]);
    endcase
  endtask

  task automatic add_pileup_line();
    string ref_set;
    int    shape;
    int    n;
    int    q;
    ref_set = "ACGTacgtN";
    shape   = $urandom_range(15);
    if (shape == 0) begin
      repeat ($urandom_range(1, 10)) text_queue.push_back(8'($urandom_range(255)));
      text_queue.push_back(psbc_pkg::CHAR_NEWLINE);
      return;
    end
    repeat ($urandom_range(3)) text_queue.push_back(8'($urandom_range(33, 126)));
    text_queue.push_back(psbc_pkg::CHAR_TAB);
    n = (shape == 1) ? $urandom_range(10, 13) : $urandom_range(1, 9);
    repeat (n) text_queue.push_back(psbc_pkg::CHAR_ZERO + 8'($urandom_range(9)));
    if (shape == 2) text_queue.push_back(plain_byte());
    text_queue.push_back(psbc_pkg::CHAR_TAB);
    case ($urandom_range(7))
      0: ;
      1: text_queue.push_back(plain_byte());
      default: text_queue.push_back(ref_set[$urandom_range(8)]);
    endcase
    if (shape == 3) text_queue.push_back(ref_set[$urandom_range(8)]);
    text_queue.push_back(psbc_pkg::CHAR_TAB);
    repeat ($urandom_range(1, 3)) text_queue.push_back(psbc_pkg::CHAR_ZERO + 8'($urandom_range(9)));
    text_queue.push_back(psbc_pkg::CHAR_TAB);
    if (shape == 4) begin
      text_queue.push_back(psbc_pkg::CHAR_NEWLINE);
      return;
    end
    n = $urandom_range(8);
    repeat (n) add_base_token();
    text_queue.push_back(psbc_pkg::CHAR_TAB);
    q = $urandom_range((n > 0) ? n - 1 : 0, n + 2);
    repeat (q) text_queue.push_back(quality_char());
    if (shape == 5) push_text("\tX\t\t\tYZ\t");
    text_queue.push_back(psbc_pkg::CHAR_NEWLINE);
  endtask

  task automatic write_threshold(input logic [psbc_pkg::MBQ_W-1:0] v);
    @(posedge clk);
    cfg_valid        <= 1'b1;
    min_base_quality <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    pu_min_qual  = v;
    @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    while (text_queue.size() != 0 || in_valid || expected_sites.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  initial begin
    logic [psbc_pkg::MBQ_W-1:0] floors [6];
    int unsigned                start_size;
    int                         lines;
    floors = '{7'd0, 7'd93, 7'd30, 7'd40, 7'd1, 7'd64};
    start_new_line();
    pu_ref_base = '0;
    pu_min_qual = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 35;
    recv_idle_pct = 83;
    write_threshold(7'd0);
    push_text("chr1\t2147483647\tA\t8\tAaTtGgCc.,*\t!!!!!!!!!!!\n");
    push_text("c\t99999999999\tg\t2\t.,\t~~\n");
    push_text("c\t1x2y3\tN\t2\t.,\t#$\n");
    push_text("c\t4\t\t1\t.\t \n");
    push_text("c\t5\tT\t6\t^].$+2AC,-12ACGTACGTACGTg*\t!!!!\n");
    push_text("c\t6\tC\t3\t+A-,+\tII\n");
    push_text("c\t7\tA\t1\t+9999999ACGT\t!\n");
    push_text("c\t8\tG\t1\tAc\t!!!!!\n");
    push_text("c\t9\tA\t1\tA\tI\tX\tY\tZ\tW\t\n");
    push_text("c\t10\tG\t3\tACG\n");
    push_text("\n");
    drain();

    write_threshold(7'd93);
    push_text("c\t13\tA\t6\tAAAAAAA\t");
    text_queue.push_back(8'd126);
    text_queue.push_back(8'd125);
    text_queue.push_back(8'd32);
    text_queue.push_back(8'd0);
    text_queue.push_back(8'd255);
    text_queue.push_back(psbc_pkg::CHAR_BANG);
    text_queue.push_back(psbc_pkg::CHAR_NEWLINE);
    drain();

    for (int chunk = 0; chunk < 6; chunk++) begin
      send_idle_pct = (chunk < 2) ? 35 : (chunk < 4) ? 83 : 0;
      recv_idle_pct = (chunk < 2) ? 83 : (chunk < 4) ? 35 : 0;
      write_threshold(floors[chunk]);
      start_size = text_queue.size();
      lines      = 0;
      while (text_queue.size() - start_size < 40 || lines < 2) begin
        add_pileup_line();
        lines++;
      end
      drain();
    end

    // hold the output while short lines keep arriving
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_off_armed = 1'b1;
    for (int i = 0; i < 12; i++)
      push_text((i % 3 == 0) ? "\n" : $sformatf("p\t%0d\tA\t1\tAc\tII\n", i));
    drain();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
